// ===== src/taylor_sine_epsilon_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Taylor sine unit assertion macros
// Shared concurrent assertion forms; the clock is clk and the reset is rst_n.
// ----------------------------------------------------------------------------
`ifndef TAYLOR_SINE_EPSILON_UNIT_DEFINES_SVH
`define TAYLOR_SINE_EPSILON_UNIT_DEFINES_SVH

// same-cycle implication
`define TSE_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// Taylor sine unit package
// Widths, microcode word layout and the microcode program.
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int FracBits = 27;
  localparam int MaxTerms = 32;

  localparam int AngleW = 31;
  localparam int EpsW   = 28;
  localparam int SineW  = 32;
  localparam int TermsW = 6;

  // |angle| <= 2^(AngleW-1)
  localparam int AbsW  = AngleW;
  localparam int X2W   = 2 * (AbsW - 1) - FracBits + 1;
  localparam int TermW = 63;
  localparam int SumW  = 64;

  localparam int MulAW = 32;
  localparam int MulBW = (X2W > AbsW) ? X2W : AbsW;
  localparam int MulPW = MulAW + MulBW;
  localparam int ProdW = TermW + X2W;

  localparam int DivBits  = 8;
  localparam int DivSteps = (TermW + DivBits - 1) / DivBits;
  localparam int DivW     = DivSteps * DivBits;
  localparam int DcW      = $clog2(DivSteps);

  localparam logic [TermW-1:0] TermCap = {1'b1, {(TermW-1){1'b0}}};

  localparam int PcW = 4;

  typedef enum logic [3:0] {
    OP_LOAD = 4'd0,
    OP_SQR  = 4'd1,
    OP_X2   = 4'd2,
    OP_TEST = 4'd3,
    OP_MLO  = 4'd4,
    OP_MHI  = 4'd5,
    OP_QUOT = 4'd6,
    OP_DIV  = 4'd7,
    OP_ACC  = 4'd8,
    OP_EMIT = 4'd9,
    OP_NOP  = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    JMP_NEVER    = 3'd0,
    JMP_ALWAYS   = 3'd1,
    JMP_NO_REQ   = 3'd2,
    JMP_STOP     = 3'd3,
    JMP_DIV_BUSY = 3'd4,
    JMP_OUT_BUSY = 3'd5
  } jmp_t;

  typedef struct packed {
    op_t            op;
    jmp_t           jmp;
    logic [PcW-1:0] target;
  } uword_t;

  typedef struct packed {
    logic no_req;
    logic stop;
    logic div_busy;
    logic out_busy;
  } flags_t;

  localparam logic [PcW-1:0] PcIdle = 4'd0;
  localparam logic [PcW-1:0] PcSqr  = 4'd1;
  localparam logic [PcW-1:0] PcX2   = 4'd2;
  localparam logic [PcW-1:0] PcTest = 4'd3;
  localparam logic [PcW-1:0] PcMlo  = 4'd4;
  localparam logic [PcW-1:0] PcMhi  = 4'd5;
  localparam logic [PcW-1:0] PcQuot = 4'd6;
  localparam logic [PcW-1:0] PcDiv  = 4'd7;
  localparam logic [PcW-1:0] PcAcc  = 4'd8;
  localparam logic [PcW-1:0] PcEmit = 4'd9;
  localparam logic [PcW-1:0] PcRet  = 4'd10;

  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      PcIdle:  w = '{op: OP_LOAD, jmp: JMP_NO_REQ,   target: PcIdle};
      PcSqr:   w = '{op: OP_SQR,  jmp: JMP_NEVER,    target: PcIdle};
      PcX2:    w = '{op: OP_X2,   jmp: JMP_NEVER,    target: PcIdle};
      PcTest:  w = '{op: OP_TEST, jmp: JMP_STOP,     target: PcEmit};
      PcMlo:   w = '{op: OP_MLO,  jmp: JMP_NEVER,    target: PcIdle};
      PcMhi:   w = '{op: OP_MHI,  jmp: JMP_NEVER,    target: PcIdle};
      PcQuot:  w = '{op: OP_QUOT, jmp: JMP_NEVER,    target: PcIdle};
      PcDiv:   w = '{op: OP_DIV,  jmp: JMP_DIV_BUSY, target: PcDiv};
      PcAcc:   w = '{op: OP_ACC,  jmp: JMP_ALWAYS,   target: PcTest};
      PcEmit:  w = '{op: OP_EMIT, jmp: JMP_OUT_BUSY, target: PcEmit};
      PcRet:   w = '{op: OP_NOP,  jmp: JMP_ALWAYS,   target: PcIdle};
      default: w = '{op: OP_NOP,  jmp: JMP_ALWAYS,   target: PcIdle};
    endcase
    return w;
  endfunction

endpackage

// ===== src/tse_seq.sv =====
// ----------------------------------------------------------------------------
// Taylor sine microsequencer
// Step counter over the microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
module tse_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  tse_pkg::flags_t flags,
  output tse_pkg::uword_t uw
);
  import tse_pkg::*;

  logic [PcW-1:0] pc_r;
  logic [PcW-1:0] pc_nxt;
  logic           take;

  assign uw = ucode(pc_r);

  always_comb begin
    case (uw.jmp)
      JMP_NEVER:    take = 1'b0;
      JMP_ALWAYS:   take = 1'b1;
      JMP_NO_REQ:   take = flags.no_req;
      JMP_STOP:     take = flags.stop;
      JMP_DIV_BUSY: take = flags.div_busy;
      JMP_OUT_BUSY: take = flags.out_busy;
      default:      take = 1'b1;
    endcase
    pc_nxt = take ? uw.target : pc_r + PcW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PcIdle;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== src/taylor_sine_epsilon_unit.sv =====
// ----------------------------------------------------------------------------
// Taylor sine unit
// Adaptive-length Taylor series for sin(x) in fixed point, microcoded.
// ----------------------------------------------------------------------------
// Channel | Ports                                        | Direction
// in      | in_valid in_stall in_angle in_epsilon        | request in
// out     | out_valid out_stall out_sine out_terms_used  | result out
//         | out_not_converged                            |
//
// Each further term: test, two passes through the shared 32x34 multiplier,
// scale, eight steps of an 8-bit-per-cycle divider, sum/saturate.
// Synchronous active-low reset returns the sequencer to idle, no result pending.
// A stalled result holds the sequencer at the emit step; in_stall is low only
// at the idle step.
// ----------------------------------------------------------------------------
`include "taylor_sine_epsilon_unit_defines.svh"

module taylor_sine_epsilon_unit #(
  parameter int MAX_TERMS = tse_pkg::MaxTerms
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [tse_pkg::AngleW-1:0]  in_angle,
  input  logic        [tse_pkg::EpsW-1:0]    in_epsilon,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tse_pkg::SineW-1:0]   out_sine,
  output logic        [tse_pkg::TermsW-1:0]  out_terms_used,
  output logic                               out_not_converged
);
  import tse_pkg::*;

  localparam int NW   = $clog2(MAX_TERMS + 1);
  localparam int DvsW = 2 * NW + 2;

  localparam logic signed [SumW-1:0] SumCap  = signed'(SumW'(TermCap));
  localparam logic signed [SumW-1:0] SineMax = signed'(SumW'({1'b0, {(SineW-1){1'b1}}}));
  localparam logic signed [SumW-1:0] SineMin = -SineMax - SumW'(1);

  uword_t uw;
  flags_t flags;

  logic                   xneg_r;
  logic [AbsW-1:0]        ax_r;
  logic [EpsW-1:0]        eps_r;
  logic [X2W-1:0]         x2_r;
  logic [TermW-1:0]       t_r;
  logic [NW-1:0]          n_r;
  logic signed [SumW-1:0] sum_r;
  logic [MulPW-1:0]       mp_r;
  logic [ProdW-1:0]       acc_r;
  logic [DivW-1:0]        dq_r;
  logic [DvsW-1:0]        rem_r;
  logic [DvsW-1:0]        dvs_r;
  logic [DcW-1:0]         dcnt_r;

  logic                   out_valid_r;
  logic signed [SineW-1:0] out_sine_r;
  logic [TermsW-1:0]      out_terms_r;
  logic                   out_nc_r;

  logic                   accept;
  logic                   out_busy;
  logic                   out_load;
  logic [AngleW:0]        neg_ext;
  logic [AbsW-1:0]        ax_c;
  logic [MulAW-1:0]       mul_a;
  logic [MulBW-1:0]       mul_b;
  logic [MulPW-1:0]       mul_p;
  logic [ProdW-1:0]       psum;
  logic [ProdW-1:0]       psh;
  logic [TermW-1:0]       q_c;
  logic [DivW-1:0]        dq_c;
  logic [DvsW:0]          rem_c;
  logic [DvsW-1:0]        dvs_c;
  logic signed [SumW-1:0] tv;
  logic signed [SumW-1:0] s2;
  logic signed [SumW-1:0] sum_c;
  logic signed [SumW-1:0] sine_c;
  logic                   t_big;

  tse_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .uw    (uw)
  );

  assign in_stall = (uw.op != OP_LOAD);
  assign accept   = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;
  assign out_load = (uw.op == OP_EMIT) && !out_busy;
  assign t_big    = t_r > TermW'(eps_r);

  assign flags.no_req   = !in_valid;
  assign flags.stop     = !(t_big && (n_r < NW'(MAX_TERMS)));
  assign flags.div_busy = dcnt_r != DcW'(DivSteps - 1);
  assign flags.out_busy = out_busy;

  // magnitude of the request angle
  assign neg_ext = -{in_angle[AngleW-1], in_angle};
  assign ax_c    = in_angle[AngleW-1] ? neg_ext[AbsW-1:0] : $unsigned(in_angle);

  // shared multiplier
  always_comb begin
    case (uw.op)
      OP_SQR: begin
        mul_a = MulAW'(ax_r);
        mul_b = MulBW'(ax_r);
      end
      OP_MLO: begin
        mul_a = t_r[MulAW-1:0];
        mul_b = MulBW'(x2_r);
      end
      default: begin
        mul_a = MulAW'(t_r[TermW-1:MulAW]);
        mul_b = MulBW'(x2_r);
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // product assembly, scaling and cap
  always_comb begin
    psum  = acc_r + (ProdW'(mp_r) << MulAW);
    psh   = psum >> FracBits;
    q_c   = (psh > ProdW'(TermCap)) ? TermCap : psh[TermW-1:0];
    dvs_c = DvsW'({n_r, 1'b0}) * DvsW'({n_r, 1'b1});
  end

  // restoring divider, DivBits quotient bits per cycle
  always_comb begin
    dq_c  = dq_r;
    rem_c = {1'b0, rem_r};
    for (int j = 0; j < DivBits; j++) begin
      rem_c = {rem_c[DvsW-1:0], dq_c[DivW-1]};
      dq_c  = {dq_c[DivW-2:0], 1'b0};
      if (rem_c >= {1'b0, dvs_r}) begin
        rem_c   = rem_c - {1'b0, dvs_r};
        dq_c[0] = 1'b1;
      end
    end
  end

  // signed accumulate with saturation; term n+1 takes the opposite sign to the angle when n is odd
  always_comb begin
    tv = signed'(SumW'(dq_r[TermW-1:0]));
    s2 = (xneg_r ^ n_r[0]) ? sum_r - tv : sum_r + tv;
    if (s2 > SumCap) begin
      sum_c = SumCap;
    end else if (s2 < -SumCap) begin
      sum_c = -SumCap;
    end else begin
      sum_c = s2;
    end
    if (sum_r > SineMax) begin
      sine_c = SineMax;
    end else if (sum_r < SineMin) begin
      sine_c = SineMin;
    end else begin
      sine_c = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= '0;
      dcnt_r <= '0;
    end else begin
      case (uw.op)
        OP_LOAD: begin
          if (accept) begin
            n_r <= NW'(1);
          end
        end
        OP_QUOT: dcnt_r <= '0;
        OP_DIV:  dcnt_r <= dcnt_r + DcW'(1);
        OP_ACC:  n_r <= n_r + NW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      OP_LOAD: begin
        if (accept) begin
          xneg_r <= in_angle[AngleW-1];
          ax_r   <= ax_c;
          eps_r  <= in_epsilon;
          t_r    <= TermW'(ax_c);
          sum_r  <= in_angle[AngleW-1] ? -signed'(SumW'(ax_c)) : signed'(SumW'(ax_c));
        end
      end
      OP_SQR: mp_r <= mul_p;
      OP_X2:  x2_r <= mp_r[FracBits +: X2W];
      OP_MLO: mp_r <= mul_p;
      OP_MHI: begin
        acc_r <= ProdW'(mp_r);
        mp_r  <= mul_p;
      end
      OP_QUOT: begin
        dq_r  <= DivW'(q_c);
        rem_r <= '0;
        dvs_r <= dvs_c;
      end
      OP_DIV: begin
        dq_r  <= dq_c;
        rem_r <= rem_c[DvsW-1:0];
      end
      OP_ACC: begin
        t_r   <= dq_r[TermW-1:0];
        sum_r <= sum_c;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sine_r  <= sine_c[SineW-1:0];
      out_terms_r <= TermsW'(n_r);
      out_nc_r    <= t_big;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sine          = out_sine_r;
  assign out_terms_used    = out_terms_r;
  assign out_not_converged = out_nc_r;

  `TSE_ASSERT_NEXT(a_accept_starts, accept, uw.op == OP_SQR, "request did not start squaring")
  `TSE_ASSERT_IMPL(a_rem_below_dvs, uw.op == OP_DIV, rem_r < dvs_r, "divider remainder overrun")
  `TSE_ASSERT_IMPL(a_out_from_emit, $rose(out_valid_r), $past(uw.op == OP_EMIT), "result without emit")
  `TSE_ASSERT_IMPL(a_term_limit, uw.op == OP_ACC, n_r < NW'(MAX_TERMS), "term count past limit")

endmodule

// ===== verif/tb_taylor_sine_epsilon_unit.sv =====
// ----------------------------------------------------------------------------
// Taylor sine unit testbench
// Sends a short table of boundary angle/tolerance requests, then random ones
// under three idling patterns. Every result is compared with a table value or a
// fixed-point series predictor built into the bench, field by field and in order.
// ----------------------------------------------------------------------------
module tb_taylor_sine_epsilon_unit;
  import tse_pkg::*;

  typedef struct packed {
    logic signed [SineW-1:0]  sine;
    logic        [TermsW-1:0] terms_used;
    logic                     not_converged;
  } sine_result_t;

  typedef struct packed {
    logic signed [AngleW-1:0] angle;
    logic        [EpsW-1:0]   epsilon;
    logic                     typed;
    sine_result_t             result;
  } request_row_t;

  localparam int          AngleLimit     = 843314857;
  localparam int          RandomPerPhase = 642;
  localparam logic [63:0] TermLimit      = 64'd1 << 62;
  localparam longint      SumLimit       = 64'sd1 <<< 62;
  localparam longint      Int32Max       = 64'sd2147483647;
  localparam longint      Int32Min       = -64'sd2147483648;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [AngleW-1:0] in_angle = '0;
  logic        [EpsW-1:0]   in_epsilon = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [SineW-1:0]  out_sine;
  logic        [TermsW-1:0] out_terms_used;
  logic                     out_not_converged;

  sine_result_t pending_result = '0;
  sine_result_t expected_sines[$];
  request_row_t directed_rows[$];
  int           failures = 0;
  int           in_gap_pct = 0;
  int           out_stall_pct = 0;

  taylor_sine_epsilon_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_angle          (in_angle),
    .in_epsilon        (in_epsilon),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sine          (out_sine),
    .out_terms_used    (out_terms_used),
    .out_not_converged (out_not_converged)
  );

  always #5 clk = ~clk;

  // floor(a*b / 2^frac), capped at 2^62
  function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> FracBits;
    return (p > {64'd0, TermLimit}) ? TermLimit : p[63:0];
  endfunction

  function automatic longint add_clamped(input longint acc, input logic [63:0] mag,
                                         input logic neg);
    longint s;
    s = neg ? acc - longint'(mag) : acc + longint'(mag);
    if (s > SumLimit) s = SumLimit;
    if (s < -SumLimit) s = -SumLimit;
    return s;
  endfunction

  function automatic sine_result_t predict_sine(input logic [AngleW-1:0] angle,
                                                input logic [EpsW-1:0] eps);
    logic         neg;
    logic [63:0]  mag;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  k;
    longint       acc;
    int           n;
    sine_result_t r;
    neg  = angle[AngleW-1];
    mag  = neg ? (64'd1 << AngleW) - 64'(angle) : 64'(angle);
    x2   = scaled_product(mag, mag);
    term = mag;
    k    = 64'd1;
    n    = 1;
    acc  = add_clamped(0, term, neg);
    while (term > 64'(eps) && n < MaxTerms) begin
      term = scaled_product(term, x2) / ((k + 64'd1) * (k + 64'd2));
      k += 64'd2;
      n++;
      // odd terms alternate in sign
      acc = add_clamped(acc, term, neg ^ (n % 2 == 0));
    end
    if (acc > Int32Max) acc = Int32Max;
    if (acc < Int32Min) acc = Int32Min;
    r.sine          = SineW'(acc);
    r.terms_used    = TermsW'(n);
    r.not_converged = term > 64'(eps);
    return r;
  endfunction

  task automatic send_request(input logic signed [AngleW-1:0] angle,
                              input logic [EpsW-1:0] eps, input sine_result_t want);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(1, 400)) @(posedge clk);
      else @(posedge clk);
    end
    in_angle       <= angle;
    in_epsilon     <= eps;
    pending_result <= want;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin : scoreboard
    sine_result_t want;
    if (rst_n && in_valid && !in_stall) expected_sines.push_back(pending_result);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sines.size() == 0) begin
        $error("unexpected result: out_sine %0d", out_sine);
        failures++;
      end else begin
        want = expected_sines.pop_front();
        if (out_sine !== want.sine) begin
          $error("out_sine expected %0d got %0d", want.sine, out_sine);
          failures++;
        end
        if (out_terms_used !== want.terms_used) begin
          $error("out_terms_used expected %0d got %0d", want.terms_used, out_terms_used);
          failures++;
        end
        if (out_not_converged !== want.not_converged) begin
          $error("out_not_converged expected %0d got %0d", want.not_converged,
                 out_not_converged);
          failures++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < out_stall_pct);
  end

  initial begin : stimulus
    request_row_t             row;
    sine_result_t             want;
    logic signed [AngleW-1:0] angle;
    logic        [EpsW-1:0]   eps;
    int unsigned              span;
    int                       v;
    int                       wait_cycles;
    // angle, epsilon, typed, {sine, terms_used, not_converged}
    directed_rows.push_back('{0, 1, 1'b1, '{0, 1, 0}});
    directed_rows.push_back('{0, 0, 1'b1, '{0, 1, 0}});
    directed_rows.push_back('{134217728, 134217728, 1'b1, '{134217728, 1, 0}});
    directed_rows.push_back('{-134217728, 134217728, 1'b1, '{-134217728, 1, 0}});
    directed_rows.push_back('{1, 1, 1'b1, '{1, 1, 0}});
    directed_rows.push_back('{-1, 28'hFFFFFFF, 1'b1, '{-1, 1, 0}});
    directed_rows.push_back('{843314857, 1, 1'b0, '0});
    directed_rows.push_back('{-843314857, 1, 1'b0, '0});
    directed_rows.push_back('{843314857, 0, 1'b0, '0});
    directed_rows.push_back('{-843314857, 0, 1'b0, '0});
    directed_rows.push_back('{843314857, 134217728, 1'b0, '0});
    directed_rows.push_back('{-843314857, 28'hFFFFFFF, 1'b0, '0});
    // out of range: full-scale 31-bit magnitudes
    directed_rows.push_back('{31'h3FFFFFFF, 0, 1'b0, '0});
    directed_rows.push_back('{31'h40000000, 0, 1'b0, '0});
    directed_rows.push_back('{31'h40000000, 1, 1'b0, '0});
    directed_rows.push_back('{31'h3FFFFFFF, 28'hFFFFFFF, 1'b0, '0});
    directed_rows.push_back('{210828714, 1, 1'b0, '0});
    directed_rows.push_back('{421657428, 0, 1'b0, '0});
    directed_rows.push_back('{-632486143, 100, 1'b0, '0});
    directed_rows.push_back('{31'h2AAAAAAA, 28'h5555555, 1'b0, '0});
    directed_rows.push_back('{31'h55555555, 28'hAAAAAAA, 1'b0, '0});
    directed_rows.push_back('{-1, 0, 1'b0, '0});
    directed_rows.push_back('{1, 0, 1'b0, '0});
    directed_rows.push_back('{13421773, 1, 1'b0, '0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    in_gap_pct    = 19;
    out_stall_pct = 56;
    foreach (directed_rows[i]) begin
      row  = directed_rows[i];
      want = row.typed ? row.result : predict_sine(row.angle, row.epsilon);
      send_request(row.angle, row.epsilon, want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      in_gap_pct    = (phase == 0) ? 19 : (phase == 1) ? 56 : 0;
      out_stall_pct = (phase == 0) ? 56 : (phase == 1) ? 19 : 0;
      repeat (RandomPerPhase) begin
        case ($urandom_range(0, 9))
          0: angle = AngleW'($urandom);
          1: begin
            span  = 32'd1 << $urandom_range(0, 27);
            v     = int'($urandom_range(0, span));
            angle = AngleW'($urandom_range(0, 1) ? -v : v);
          end
          default: angle = AngleW'(int'($urandom_range(0, 2 * AngleLimit)) - AngleLimit);
        endcase
        case ($urandom_range(0, 9))
          0: eps = '0;
          1: eps = EpsW'($urandom);
          default: eps = EpsW'($urandom_range(1, 134217728) >> $urandom_range(0, 27));
        endcase
        send_request(angle, eps, predict_sine(angle, eps));
      end
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (expected_sines.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (400) @(posedge clk);
    @(negedge clk);
    if (expected_sines.size() != 0) begin
      $error("%0d results never arrived", expected_sines.size());
      failures++;
    end
    if (failures == 0) begin
      $display("** taylor_sine_epsilon_unit: PASSED **");
    end else begin
      $display("** taylor_sine_epsilon_unit: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("** taylor_sine_epsilon_unit: FAILED **");
    $finish;
  end

endmodule
